>>> design/att_pkg.sv
package att_pkg;

    localparam int FORCE_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Root width; force width plus the fraction shift is always this
    localparam int ROOT_W       = 32;
    localparam int RAD_W        = 2 * ROOT_W;
    localparam int REM_W        = ROOT_W + 2;
    localparam int SQ_PER_STAGE = 2;
    localparam int SQ_STAGES    = ROOT_W / SQ_PER_STAGE;

    localparam int PRE_SHIFT = 24;
    localparam int TABLE_LEN = 24;
    localparam int XY_W      = ROOT_W + PRE_SHIFT + 3;
    localparam int Z_W       = 25;
    localparam int OUT_W     = 16;
    localparam int ORIENT_W  = 9;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_ORIENTATION = '0;

    localparam logic signed [Z_W-1:0]   ANGLE_90_Q16 = Z_W'(5898240);
    localparam logic signed [OUT_W-1:0] ANGLE_90_Q8  = OUT_W'(23040);
    localparam logic signed [Z_W-1:0]   ROUND_HALF   = Z_W'(128);

    // atan(2^-i) in degrees, Q16
    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            0:       v = Z_W'(2949120);
            1:       v = Z_W'(1740967);
            2:       v = Z_W'(919879);
            3:       v = Z_W'(466945);
            4:       v = Z_W'(234379);
            5:       v = Z_W'(117304);
            6:       v = Z_W'(58666);
            7:       v = Z_W'(29335);
            8:       v = Z_W'(14668);
            9:       v = Z_W'(7334);
            10:      v = Z_W'(3667);
            11:      v = Z_W'(1833);
            12:      v = Z_W'(917);
            13:      v = Z_W'(458);
            14:      v = Z_W'(229);
            15:      v = Z_W'(115);
            16:      v = Z_W'(57);
            17:      v = Z_W'(29);
            18:      v = Z_W'(14);
            19:      v = Z_W'(7);
            20:      v = Z_W'(4);
            21:      v = Z_W'(2);
            22:      v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/att_angle_pipe.sv
module att_angle_pipe
    import att_pkg::*;
#(
    parameter int FORCE_WIDTH  = FORCE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    localparam int CORDIC_N    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN,
    localparam int STAGES      = SQ_STAGES + CORDIC_N + 1
) (
    input  logic                        i_clk,
    input  logic [STAGES-1:0]           i_en,
    input  logic [2*FORCE_WIDTH-1:0]    i_sum,
    input  logic [FORCE_WIDTH-1:0]      i_mag,
    input  logic                        i_neg,
    output logic signed [OUT_W-1:0]     o_angle
);

    localparam int FRAC = ROOT_W - FORCE_WIDTH;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } t_sq;

    // One digit of the restoring square root: bring down two radicand bits
    function automatic t_sq sq_step(input t_sq s);
        t_sq              r;
        logic [REM_W+1:0] w;
        logic [REM_W+1:0] trial;
        w     = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (w >= trial) begin
            r.rem  = REM_W'(w - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = REM_W'(w);
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    t_sq               r_sq    [SQ_STAGES];
    logic [ROOT_W-1:0] r_mag_s [SQ_STAGES];
    logic              r_mz_s  [SQ_STAGES];
    logic              r_dz_s  [SQ_STAGES];
    logic              r_neg_s [SQ_STAGES];

    logic signed [XY_W-1:0] r_x     [CORDIC_N];
    logic signed [XY_W-1:0] r_y     [CORDIC_N];
    logic signed [Z_W-1:0]  r_z     [CORDIC_N];
    logic                   r_mz_c  [CORDIC_N];
    logic                   r_dz_c  [CORDIC_N];
    logic                   r_neg_c [CORDIC_N];

    logic signed [OUT_W-1:0] r_angle;

    // Square root, SQ_PER_STAGE digits per stage
    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sq
        t_sq               st_in;
        t_sq               st_out;
        logic [ROOT_W-1:0] mag_in;
        logic              mz_in;
        logic              dz_in;
        logic              neg_in;

        if (s == 0) begin : g_first
            assign st_in.rad  = RAD_W'(i_sum) << (2 * FRAC);
            assign st_in.root = '0;
            assign st_in.rem  = '0;
            assign mag_in     = ROOT_W'(i_mag) << FRAC;
            assign mz_in      = (i_mag == '0);
            assign dz_in      = (i_sum == '0);
            assign neg_in     = i_neg;
        end else begin : g_next
            assign st_in  = r_sq[s-1];
            assign mag_in = r_mag_s[s-1];
            assign mz_in  = r_mz_s[s-1];
            assign dz_in  = r_dz_s[s-1];
            assign neg_in = r_neg_s[s-1];
        end

        always_comb begin
            st_out = st_in;
            for (int j = 0; j < SQ_PER_STAGE; j++) begin
                st_out = sq_step(st_out);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_sq[s]    <= st_out;
                r_mag_s[s] <= mag_in;
                r_mz_s[s]  <= mz_in;
                r_dz_s[s]  <= dz_in;
                r_neg_s[s] <= neg_in;
            end
        end
    end

    // Vectoring CORDIC, one micro-rotation per stage
    for (genvar c = 0; c < CORDIC_N; c++) begin : g_cr
        logic signed [XY_W-1:0] x_in;
        logic signed [XY_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [XY_W-1:0] n_x;
        logic signed [XY_W-1:0] n_y;
        logic signed [Z_W-1:0]  n_z;
        logic                   mz_in;
        logic                   dz_in;
        logic                   neg_in;

        if (c == 0) begin : g_first
            assign x_in   = $signed({3'b000, r_sq[SQ_STAGES-1].root, PRE_SHIFT'(0)});
            assign y_in   = $signed({3'b000, r_mag_s[SQ_STAGES-1], PRE_SHIFT'(0)});
            assign z_in   = '0;
            assign mz_in  = r_mz_s[SQ_STAGES-1];
            assign dz_in  = r_dz_s[SQ_STAGES-1];
            assign neg_in = r_neg_s[SQ_STAGES-1];
        end else begin : g_next
            assign x_in   = r_x[c-1];
            assign y_in   = r_y[c-1];
            assign z_in   = r_z[c-1];
            assign mz_in  = r_mz_c[c-1];
            assign dz_in  = r_dz_c[c-1];
            assign neg_in = r_neg_c[c-1];
        end

        always_comb begin
            dx = y_in >>> c;
            dy = x_in >>> c;
            if (!y_in[XY_W-1]) begin
                n_x = x_in + dx;
                n_y = y_in - dy;
                n_z = z_in + atan_q16(c);
            end else begin
                n_x = x_in - dx;
                n_y = y_in + dy;
                n_z = z_in - atan_q16(c);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[SQ_STAGES+c]) begin
                r_x[c]     <= n_x;
                r_y[c]     <= n_y;
                r_z[c]     <= n_z;
                r_mz_c[c]  <= mz_in;
                r_dz_c[c]  <= dz_in;
                r_neg_c[c] <= neg_in;
            end
        end
    end

    // Clamp to [0, 90], round to Q8.8, apply special cases and sign
    logic signed [Z_W-1:0]   z_clamp;
    logic signed [Z_W-1:0]   z_round;
    logic signed [OUT_W-1:0] q_mag;
    logic signed [OUT_W-1:0] n_angle;

    always_comb begin
        if (r_z[CORDIC_N-1] < 0) begin
            z_clamp = '0;
        end else if (r_z[CORDIC_N-1] > ANGLE_90_Q16) begin
            z_clamp = ANGLE_90_Q16;
        end else begin
            z_clamp = r_z[CORDIC_N-1];
        end
        z_round = z_clamp + ROUND_HALF;
        if (r_mz_c[CORDIC_N-1]) begin
            q_mag = '0;
        end else if (r_dz_c[CORDIC_N-1]) begin
            q_mag = ANGLE_90_Q8;
        end else begin
            q_mag = OUT_W'(z_round[Z_W-1:8]);
        end
        n_angle = r_neg_c[CORDIC_N-1] ? -q_mag : q_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[STAGES-1]) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

>>> design/accelerometer_tilt_angles.sv
// Accelerometer tilt angles: pitch and roll from one three-axis sample.
//
// Input channel: i_valid / o_stall carry force_x, force_y, force_z (signed
// Q4.12 g). A transaction completes on a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall carry pitch_deg and roll_deg
// (signed Q8.8 degrees), one result per input transaction, in order.
// The APB port holds the orientation register at address 0; a value of zero
// negates all three axes, which mirrors both angles.
//
// The pipeline has 20 + min(CORDIC_STEPS, 24) register stages (36 by default):
// three for magnitudes, squares and sums, 16 for the square root at two root
// bits per stage, one per CORDIC micro-rotation, and the output register.
// It takes one transaction per clock unless stalled. Every stage only
// advances when it is empty or the stage after it advances, so a stalled
// output keeps taking input until the pipeline has no empty slot left.
// Reset clears the valid bits and the orientation register; o_valid drops and
// in-flight transactions are dropped. While o_valid and i_stall are high the
// output register holds its value.
module accelerometer_tilt_angles
    import att_pkg::*;
#(
    parameter int FORCE_WIDTH  = FORCE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [FORCE_WIDTH-1:0] i_force_x,
    input  logic signed [FORCE_WIDTH-1:0] i_force_y,
    input  logic signed [FORCE_WIDTH-1:0] i_force_z,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [OUT_W-1:0]       o_pitch_deg,
    output logic signed [OUT_W-1:0]       o_roll_deg,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_AW-1:0]             paddr,
    input  logic [APB_DW-1:0]             pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready
);

    localparam int CORDIC_N    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int PIPE_STAGES = SQ_STAGES + CORDIC_N + 1;
    localparam int FRONT       = 3;
    localparam int DEPTH       = FRONT + PIPE_STAGES;
    localparam int SQW         = 2 * FORCE_WIDTH;

    // Configuration
    logic [ORIENT_W-1:0] r_orient;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_ORIENTATION) ? APB_DW'(r_orient) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= '0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[APB_AW-1:2] == REG_ORIENTATION) begin
            r_orient <= pwdata[ORIENT_W-1:0];
        end
    end

    // Flow control: stage k moves when some stage from k to the end is empty
    // or the output is taken.
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic [DEPTH-1:0] en;

    for (genvar k = 0; k < DEPTH; k++) begin : g_en
        assign en[k] = !i_stall || !(&r_vld[DEPTH-1:k]);
    end

    assign n_vld   = {r_vld[DEPTH-2:0], i_valid};
    assign o_stall = !en[0];
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < DEPTH; k++) begin
                if (en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Stage 0: magnitudes and result signs after the orientation flip
    logic                   neg_cfg;
    logic [FORCE_WIDTH-1:0] n_mag_x;
    logic [FORCE_WIDTH-1:0] n_mag_y;
    logic [FORCE_WIDTH-1:0] n_mag_z;
    logic                   n_neg_x;
    logic                   n_neg_y;

    always_comb begin
        neg_cfg = (r_orient == '0);
        n_mag_x = i_force_x[FORCE_WIDTH-1] ? FORCE_WIDTH'(-i_force_x) : FORCE_WIDTH'(i_force_x);
        n_mag_y = i_force_y[FORCE_WIDTH-1] ? FORCE_WIDTH'(-i_force_y) : FORCE_WIDTH'(i_force_y);
        n_mag_z = i_force_z[FORCE_WIDTH-1] ? FORCE_WIDTH'(-i_force_z) : FORCE_WIDTH'(i_force_z);
        n_neg_x = neg_cfg ? (!i_force_x[FORCE_WIDTH-1] && i_force_x != '0)
                          : i_force_x[FORCE_WIDTH-1];
        n_neg_y = neg_cfg ? (!i_force_y[FORCE_WIDTH-1] && i_force_y != '0)
                          : i_force_y[FORCE_WIDTH-1];
    end

    logic [FORCE_WIDTH-1:0] r_mag_x0, r_mag_y0, r_mag_z0;
    logic                   r_neg_x0, r_neg_y0;
    logic [SQW-1:0]         r_sq_x, r_sq_y, r_sq_z;
    logic [FORCE_WIDTH-1:0] r_mag_x1, r_mag_y1;
    logic                   r_neg_x1, r_neg_y1;
    logic [SQW-1:0]         r_sum_p, r_sum_r;
    logic [FORCE_WIDTH-1:0] r_mag_x2, r_mag_y2;
    logic                   r_neg_x2, r_neg_y2;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_mag_x0 <= n_mag_x;
            r_mag_y0 <= n_mag_y;
            r_mag_z0 <= n_mag_z;
            r_neg_x0 <= n_neg_x;
            r_neg_y0 <= n_neg_y;
        end
        if (en[1]) begin
            r_sq_x   <= SQW'(r_mag_x0) * SQW'(r_mag_x0);
            r_sq_y   <= SQW'(r_mag_y0) * SQW'(r_mag_y0);
            r_sq_z   <= SQW'(r_mag_z0) * SQW'(r_mag_z0);
            r_mag_x1 <= r_mag_x0;
            r_mag_y1 <= r_mag_y0;
            r_neg_x1 <= r_neg_x0;
            r_neg_y1 <= r_neg_y0;
        end
        if (en[2]) begin
            // squares are at most 2^(2W-2), so the sums fit
            r_sum_p  <= r_sq_x + r_sq_z;
            r_sum_r  <= r_sq_y + r_sq_z;
            r_mag_x2 <= r_mag_x1;
            r_mag_y2 <= r_mag_y1;
            r_neg_x2 <= r_neg_x1;
            r_neg_y2 <= r_neg_y1;
        end
    end

    // pitch = atan(y / sqrt(x^2 + z^2))
    att_angle_pipe #(
        .FORCE_WIDTH  (FORCE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_en    (en[DEPTH-1:FRONT]),
        .i_sum   (r_sum_p),
        .i_mag   (r_mag_y2),
        .i_neg   (r_neg_y2),
        .o_angle (o_pitch_deg)
    );

    // roll = atan(x / sqrt(y^2 + z^2))
    att_angle_pipe #(
        .FORCE_WIDTH  (FORCE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_roll (
        .i_clk   (i_clk),
        .i_en    (en[DEPTH-1:FRONT]),
        .i_sum   (r_sum_r),
        .i_mag   (r_mag_x2),
        .i_neg   (r_neg_x2),
        .o_angle (o_roll_deg)
    );

endmodule

>>> design/att_checker.sv
module att_checker
    import att_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [OUT_W-1:0] o_pitch_deg,
    input logic signed [OUT_W-1:0] o_roll_deg
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pitch_deg) && $stable(o_roll_deg))
        else $error("output transaction changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_deg <= ANGLE_90_Q8) && (o_pitch_deg >= -ANGLE_90_Q8) &&
                    (o_roll_deg <= ANGLE_90_Q8) && (o_roll_deg >= -ANGLE_90_Q8))
        else $error("angle outside +/-90 degrees");

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result left over after reset");

    // back pressure only when the output itself is blocked
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled with a free output");

endmodule

bind accelerometer_tilt_angles att_checker u_att_checker (.*);
